@@ src/kmer_match_counter_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef KMER_MATCH_COUNTER_CORE_ASSERT_SVH
`define KMER_MATCH_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define KMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define KMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/kmc_pkg.sv @@
// Types and constants for the k-mer match counter.
package kmc_pkg;

    localparam int KEY_W_MAX = 62;

    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_BEGIN = 3'd1;
    localparam logic [2:0] ACT_SCAN  = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Multiplicative hash constant, split in 32-bit halves.
    localparam logic [31:0] HASH_LO = 32'h7F4A7C15;
    localparam logic [31:0] HASH_HI = 32'h9E3779B9;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] base;
        logic [7:0] kmer_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        kmer_done;
        logic        hit;
        logic [7:0]  hit_kmer;
        logic        hit_reverse;
        logic [31:0] hit_position;
        logic [31:0] count_value;
        logic [39:0] windows_seen;
        logic [8:0]  kmers_loaded;
    } t_rsp;

    typedef enum logic [2:0] {
        OP_NOP       = 3'd0,
        OP_LOAD_DONE = 3'd1,
        OP_SCAN      = 3'd2,
        OP_READ      = 3'd3,
        OP_CLEAR     = 3'd4
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [KEY_W_MAX-1:0]  fwd;
        logic [KEY_W_MAX-1:0]  rev;
        logic [31:0]           pos;
        logic [7:0]            idx;
    } t_cmd;

endpackage

@@ src/kmc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kmc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                         i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/kmc_fifo.sv @@
// Two-entry command queue between front and back.
module kmc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kmc_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output kmc_pkg::t_cmd o_data
);
    import kmc_pkg::*;

    t_cmd       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_ent[r_rp];
endmodule

@@ src/kmc_front.sv @@
// Front end: packs load keys, rolls the scan window, classifies each request.
module kmc_front #(
    parameter int KMER_LEN = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  kmc_pkg::t_req i_req,
    input  logic          i_q_full,
    input  logic          i_hold,
    output logic          o_push,
    output kmc_pkg::t_cmd o_cmd
);
    import kmc_pkg::*;

    localparam int KW = 2 * KMER_LEN;
    localparam int LW = $clog2(KMER_LEN + 1);

    logic [KW-1:0] r_lf, r_lr, n_lf, n_lr, r_win, n_win;
    logic [LW-1:0] r_len, n_len;
    logic [31:0]   r_pos, n_pos;
    logic          acc;
    t_cmd          cmd;

    assign o_req_stall = i_q_full | i_hold;
    assign acc         = i_req_valid & ~o_req_stall;

    always_comb begin
        n_lf  = r_lf;
        n_lr  = r_lr;
        n_len = r_len;
        n_win = r_win;
        n_pos = r_pos;
        cmd   = '0;
        cmd.op  = OP_NOP;
        cmd.idx = i_req.kmer_index;
        unique case (i_req.action)
            ACT_LOAD: begin
                n_lf  = {r_lf[KW-3:0], i_req.base};
                n_lr  = {2'(2'd3 - i_req.base), r_lr[KW-1:2]};
                n_len = r_len + LW'(1);
                if (32'(n_len) >= KMER_LEN) begin
                    cmd.op  = OP_LOAD_DONE;
                    cmd.fwd = KEY_W_MAX'(n_lf);
                    cmd.rev = KEY_W_MAX'(n_lr);
                    n_lf  = '0;
                    n_lr  = '0;
                    n_len = '0;
                end
            end
            ACT_BEGIN: begin
                n_win = '0;
                n_pos = '0;
            end
            ACT_SCAN: begin
                n_win = {r_win[KW-3:0], i_req.base};
                if (r_pos != 32'hFFFF_FFFF) n_pos = r_pos + 32'd1;
                if (n_pos >= 32'(KMER_LEN)) begin
                    cmd.op  = OP_SCAN;
                    cmd.fwd = KEY_W_MAX'(n_win);
                    cmd.pos = n_pos;
                end
            end
            ACT_READ:  cmd.op = OP_READ;
            ACT_CLEAR: cmd.op = OP_CLEAR;
            default:   cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lf  <= '0;
            r_lr  <= '0;
            r_len <= '0;
            r_win <= '0;
            r_pos <= '0;
        end else if (acc) begin
            r_lf  <= n_lf;
            r_lr  <= n_lr;
            r_len <= n_len;
            r_win <= n_win;
            r_pos <= n_pos;
        end
    end

    assign o_push = acc;
    assign o_cmd  = cmd;
endmodule

@@ src/kmc_back.sv @@
// Back end: hash probes, key inserts, hit counting and the result register.
module kmc_back #(
    parameter int KMER_LEN    = 31,
    parameter int MAX_KMERS   = 256,
    parameter int TABLE_SLOTS = 512,
    parameter int COUNT_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  kmc_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output kmc_pkg::t_rsp o_rsp
);
    import kmc_pkg::*;

    localparam int KW     = 2 * KMER_LEN;
    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CIW    = (MAX_KMERS > 1) ? $clog2(MAX_KMERS) : 1;
    localparam int TAG_W  = CIW + 1;
    localparam int KTW    = $clog2(MAX_KMERS + 1);
    localparam int KEW    = 1 + TAG_W + KW;
    localparam logic [SLOT_W:0]   NSL  = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(TABLE_SLOTS - 1);

    typedef enum logic [10:0] {
        S_CLR   = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_HASH0 = 11'b000_0000_0100,
        S_HASH1 = 11'b000_0000_1000,
        S_HASH2 = 11'b000_0001_0000,
        S_MOD   = 11'b000_0010_0000,
        S_PRD   = 11'b000_0100_0000,
        S_PCHK  = 11'b000_1000_0000,
        S_CRD   = 11'b001_0000_0000,
        S_CUPD  = 11'b010_0000_0000,
        S_COUT  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [KW-1:0]      r_fwd, n_fwd, r_rev, n_rev, r_key, n_key;
    logic [31:0]        r_pos, n_pos, r_acc, n_acc, r_h, n_h, r_hp, n_hp;
    logic [SLOT_W:0]    r_rem, n_rem;
    logic [1:0]         r_mcnt, n_mcnt, r_phase, n_phase;
    logic [SLOT_W-1:0]  r_slot, n_slot, r_pn, n_pn, r_clr, n_clr;
    logic               r_dup, n_dup, r_hr, n_hr;
    logic [CIW-1:0]     r_cidx, n_cidx;
    logic [MAX_KMERS-1:0] r_cval, n_cval;
    logic [KTW-1:0]     r_ktotal, n_ktotal;
    logic [39:0]        r_wtotal, n_wtotal;
    t_rsp               r_out, n_out;
    logic               r_ovalid, n_ovalid;

    logic               kwe, cwe;
    logic [SLOT_W-1:0]  kwaddr, kraddr;
    logic [KEW-1:0]     kwdata, krdata;
    logic [CIW-1:0]     caddr;
    logic [COUNT_WIDTH-1:0] cwdata, crdata, cnt;
    logic [63:0]        key64, prod, c64;
    logic [31:0]        ma, mb;
    logic [SLOT_W:0]    t;
    logic               out_free, fin, rv, found, endp, full;
    logic [TAG_W-1:0]   rtag, tag0;
    logic [1:0]         f_status;
    logic               f_done, f_hit;
    logic [31:0]        f_cv;

    kmc_ram #(.W(KEW), .D(TABLE_SLOTS)) u_keys (
        .i_clk(i_clk), .i_we(kwe), .i_waddr(kwaddr), .i_wdata(kwdata),
        .i_raddr(kraddr), .o_rdata(krdata)
    );

    kmc_ram #(.W(COUNT_WIDTH), .D(MAX_KMERS)) u_counts (
        .i_clk(i_clk), .i_we(cwe), .i_waddr(caddr), .i_wdata(cwdata),
        .i_raddr(caddr), .o_rdata(crdata)
    );

    assign out_free = ~r_ovalid | ~i_rsp_stall;
    assign key64    = 64'(r_key);
    // One shared 32x32 multiplier; hash bits 63:32 built in S_HASH0, S_HASH1 and S_HASH2.
    assign ma   = (r_state == S_HASH2) ? key64[63:32] : key64[31:0];
    assign mb   = (r_state == S_HASH1) ? HASH_HI : HASH_LO;
    assign prod = 64'(ma) * 64'(mb);

    assign rv    = krdata[KEW-1];
    assign rtag  = krdata[KEW-2 -: TAG_W];
    assign found = rv && (krdata[KW-1:0] == r_key);
    assign endp  = ~rv | found | (r_pn == LAST);
    assign tag0  = {r_ktotal[CIW-1:0], 1'b0};
    assign full  = (32'(r_ktotal) >= MAX_KMERS) ||
                   (TABLE_SLOTS < 2 * 32'(r_ktotal) + 2);
    assign cnt   = r_cval[r_cidx] ? crdata : '0;
    assign c64   = 64'(cnt);

    always_comb begin
        n_state = r_state;  n_op = r_op;     n_fwd = r_fwd;   n_rev = r_rev;
        n_key = r_key;      n_pos = r_pos;   n_acc = r_acc;   n_h = r_h;
        n_hp = r_hp;        n_rem = r_rem;   n_mcnt = r_mcnt; n_phase = r_phase;
        n_slot = r_slot;    n_pn = r_pn;     n_clr = r_clr;   n_dup = r_dup;
        n_hr = r_hr;        n_cidx = r_cidx; n_cval = r_cval;
        n_ktotal = r_ktotal; n_wtotal = r_wtotal;
        n_out = r_out;
        n_ovalid = r_ovalid & i_rsp_stall;
        fin = 1'b0;  f_status = ST_OK;  f_done = 1'b0;  f_hit = 1'b0;  f_cv = '0;
        o_pop = 1'b0;
        kwe = 1'b0;  kwaddr = r_slot;  kwdata = '0;  kraddr = r_slot;
        cwe = 1'b0;  caddr = r_cidx;   cwdata = '0;
        t = r_rem;
        unique case (r_state)
            S_CLR: begin
                kwe    = 1'b1;
                kwaddr = r_clr;
                if (r_clr == LAST) n_state = S_IDLE;
                else n_clr = r_clr + SLOT_W'(1);
            end
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_pop   = 1'b1;
                    n_op    = i_cmd.op;
                    n_fwd   = i_cmd.fwd[KW-1:0];
                    n_rev   = i_cmd.rev[KW-1:0];
                    n_key   = i_cmd.fwd[KW-1:0];
                    n_pos   = i_cmd.pos;
                    n_phase = 2'd0;
                    n_hr    = 1'b0;
                    unique case (i_cmd.op)
                        OP_LOAD_DONE: n_state = S_HASH0;
                        OP_SCAN: begin
                            n_wtotal = r_wtotal + 40'd1;
                            n_state  = S_HASH0;
                        end
                        OP_READ: begin
                            if (32'(i_cmd.idx) >= 32'(r_ktotal) ||
                                32'(i_cmd.idx) >= MAX_KMERS) begin
                                fin      = 1'b1;
                                f_status = ST_RANGE;
                            end else begin
                                n_cidx  = CIW'(i_cmd.idx);
                                n_state = S_CRD;
                            end
                        end
                        OP_CLEAR: begin
                            n_cval   = '0;
                            n_wtotal = '0;
                            fin      = 1'b1;
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            S_HASH0: begin
                n_acc   = prod[63:32];
                n_state = S_HASH1;
            end
            S_HASH1: begin
                n_acc   = r_acc + prod[31:0];
                n_state = S_HASH2;
            end
            S_HASH2: begin
                n_h     = r_acc + prod[31:0];
                n_rem   = '0;
                n_mcnt  = 2'd0;
                n_state = S_MOD;
            end
            S_MOD: begin
                // Remainder by the slot count, eight hash bits per cycle.
                for (int j = 0; j < 8; j++) begin
                    t = {t[SLOT_W-1:0], r_h[31-j]};
                    if (t >= NSL) t = t - NSL;
                end
                n_rem  = t;
                n_h    = r_h << 8;
                n_mcnt = r_mcnt + 2'd1;
                if (r_mcnt == 2'd3) begin
                    n_slot  = t[SLOT_W-1:0];
                    n_pn    = '0;
                    n_state = S_PRD;
                end
            end
            S_PRD: n_state = S_PCHK;
            S_PCHK: begin
                if (!endp) begin
                    n_slot  = (r_slot == LAST) ? '0 : r_slot + SLOT_W'(1);
                    n_pn    = r_pn + SLOT_W'(1);
                    n_state = S_PRD;
                end else if (r_op == OP_SCAN) begin
                    if (found) begin
                        n_hr    = rtag[0];
                        n_cidx  = rtag[TAG_W-1:1];
                        n_hp    = rtag[0] ? r_pos - 32'd1 : r_pos - 32'(KMER_LEN);
                        n_state = S_CRD;
                    end else begin
                        fin     = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    unique case (r_phase)
                        2'd0: begin
                            n_dup   = found;
                            n_phase = 2'd1;
                            n_key   = r_rev;
                            n_state = S_HASH0;
                        end
                        2'd1: begin
                            if (r_dup || found || r_fwd == r_rev) begin
                                fin = 1'b1;  f_done = 1'b1;  f_status = ST_DUP;
                                n_state = S_IDLE;
                            end else if (full) begin
                                fin = 1'b1;  f_done = 1'b1;  f_status = ST_FULL;
                                n_state = S_IDLE;
                            end else begin
                                n_phase = 2'd2;
                                n_key   = r_fwd;
                                n_state = S_HASH0;
                            end
                        end
                        2'd2: begin
                            kwe     = 1'b1;
                            kwdata  = {1'b1, tag0, r_fwd};
                            n_phase = 2'd3;
                            n_key   = r_rev;
                            n_state = S_HASH0;
                        end
                        default: begin
                            kwe      = 1'b1;
                            kwdata   = {1'b1, tag0 | TAG_W'(1), r_rev};
                            n_ktotal = r_ktotal + KTW'(1);
                            fin      = 1'b1;
                            f_done   = 1'b1;
                            n_state  = S_IDLE;
                        end
                    endcase
                end
            end
            S_CRD: n_state = (r_op == OP_SCAN) ? S_CUPD : S_COUT;
            S_CUPD: begin
                if (cnt != '1) begin
                    cwe    = 1'b1;
                    cwdata = cnt + COUNT_WIDTH'(1);
                    n_cval[r_cidx] = 1'b1;
                end
                fin     = 1'b1;
                f_hit   = 1'b1;
                n_state = S_IDLE;
            end
            S_COUT: begin
                f_cv    = (|c64[63:32]) ? 32'hFFFF_FFFF : c64[31:0];
                fin     = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (fin) begin
            n_ovalid           = 1'b1;
            n_out.status       = f_status;
            n_out.kmer_done    = f_done;
            n_out.hit          = f_hit;
            n_out.hit_kmer     = f_hit ? 8'(r_cidx) : 8'd0;
            n_out.hit_reverse  = f_hit & r_hr;
            n_out.hit_position = f_hit ? r_hp : 32'd0;
            n_out.count_value  = f_cv;
            n_out.windows_seen = n_wtotal;
            n_out.kmers_loaded = 9'(n_ktotal);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_cval   <= '0;
            r_ktotal <= '0;
            r_wtotal <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cval   <= n_cval;
            r_ktotal <= n_ktotal;
            r_wtotal <= n_wtotal;
            r_ovalid <= n_ovalid;
        end
        r_op <= n_op;     r_fwd <= n_fwd;   r_rev <= n_rev;   r_key <= n_key;
        r_pos <= n_pos;   r_acc <= n_acc;   r_h <= n_h;       r_hp <= n_hp;
        r_rem <= n_rem;   r_mcnt <= n_mcnt; r_phase <= n_phase;
        r_slot <= n_slot; r_pn <= n_pn;     r_dup <= n_dup;   r_hr <= n_hr;
        r_cidx <= n_cidx; r_out <= n_out;
    end

    assign o_clearing  = (r_state == S_CLR);
    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_out;
endmodule

@@ src/kmer_match_counter_core.sv @@
// Top level of the k-mer match counter: front end, command queue, back end.
// A scan window costs one hash probe and a completed k-mer 2 or 4 probes.
// Throughput: one request at a time in the back end, set by the shared hash multiplier,
//   the 8-bit-per-cycle slot remainder and the single key-table read port.
// Reset: synchronous active low; then a pass over every slot clears the key table,
//   during which request stall is held high.
module kmer_match_counter_core #(
    parameter int KMER_LEN    = 31,
    parameter int MAX_KMERS   = 256,
    parameter int TABLE_SLOTS = 512,
    parameter int COUNT_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  kmc_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output kmc_pkg::t_rsp o_rsp
);
    import kmc_pkg::*;

    // Request flow: front classifies and keeps the rolling registers,
    // queue decouples it from the table work in the back end.
    logic q_push, q_full, q_pop, q_valid, clearing;
    t_cmd q_in, q_out;

    kmc_front #(.KMER_LEN(KMER_LEN)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_stall(o_req_stall), .i_req(i_req),
        .i_q_full(q_full), .i_hold(clearing),
        .o_push(q_push), .o_cmd(q_in)
    );

    kmc_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_data(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_data(q_out)
    );

    // Back end holds the result register, so a finished result waits
    // there while the front keeps taking requests until the queue is full.
    kmc_back #(
        .KMER_LEN(KMER_LEN), .MAX_KMERS(MAX_KMERS),
        .TABLE_SLOTS(TABLE_SLOTS), .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(q_valid), .i_cmd(q_out), .o_pop(q_pop),
        .o_clearing(clearing),
        .o_rsp_valid(o_rsp_valid), .i_rsp_stall(i_rsp_stall), .o_rsp(o_rsp)
    );
endmodule

@@ src/kmc_checker.sv @@
// Port-level checker for the k-mer match counter, bound to the top level.
`include "kmer_match_counter_core_assert.svh"
module kmc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_rsp_valid,
    input logic          i_rsp_stall,
    input kmc_pkg::t_rsp o_rsp
);
    import kmc_pkg::*;

    `KMC_ASSERT_IMP(a_done_status, i_clk, i_rst_n, o_rsp_valid && o_rsp.kmer_done, o_rsp.status != ST_RANGE, "load result with range status")
    `KMC_ASSERT_IMP(a_hit_clean, i_clk, i_rst_n, o_rsp_valid && o_rsp.hit, o_rsp.status == ST_OK && !o_rsp.kmer_done, "hit on non-scan result")
    `KMC_ASSERT_IMP(a_nohit_zero, i_clk, i_rst_n, o_rsp_valid && !o_rsp.hit, o_rsp.hit_kmer == 8'd0 && !o_rsp.hit_reverse && o_rsp.hit_position == 32'd0, "hit fields set without hit")
    `KMC_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_rsp), "stalled result changed")
endmodule

bind kmer_match_counter_core kmc_checker u_kmc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_rsp_valid(o_rsp_valid), .i_rsp_stall(i_rsp_stall), .o_rsp(o_rsp)
);
